[rtl/esmt_pkg.sv]
// ----------------------------------------------------------------------------
// esmt_pkg: shared types and codes of the event subscriber match table
// Request and result codes, the stored entry record, the controller state
// type and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package esmt_pkg;

    localparam logic [1:0] REQ_EVENT      = 2'd0;
    localparam logic [1:0] REQ_REGISTER   = 2'd1;
    localparam logic [1:0] REQ_DEREGISTER = 2'd2;

    localparam logic [1:0] RES_DELIVERY  = 2'd0;
    localparam logic [1:0] RES_REG_ACK   = 2'd1;
    localparam logic [1:0] RES_DEREG_ACK = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic       direction;
        logic [4:0] chan_lo;
        logic [4:0] chan_hi;
        logic [3:0] type_filter;
        logic [7:0] subscriber;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVENT,
        ST_DEREG
    } state_t;

    typedef struct packed {
        logic load;
        logic do_register;
        logic start_scan;
        logic issue;
        logic dereg_mode;
        logic ev_finish;
        logic dr_finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic all_issued;
        logic rd_valid;
    } dp_status_t;

endpackage

[rtl/event_subscriber_match_table_top.sv]
// ----------------------------------------------------------------------------
// event_subscriber_match_table_top: MIDI event subscription table
// A request transaction is taken when start is high and busy is low. Results
// leave on the result ports for one cycle each, marked by result_valid, and
// the final result of a request carries last. The receiver cannot stall.
// A register request never raises busy; its acknowledge appears in the cycle
// after the transaction, so a new request can follow in the next cycle.
// An event request raises busy while the stored entries are read one per
// cycle from the entry memory; its deliveries appear in table order, each
// held back until the next match or the end of the scan shows whether it is
// the final one. A deregister request also raises busy while it reads the
// entries, compacts the kept entries in place and ends with one acknowledge.
// No new request is taken until its scan is over, since busy stays high; the
// entries all pass through the single memory read port.
// Reset empties the table at once; entry contents are not cleared.
// ----------------------------------------------------------------------------
module event_subscriber_match_table_top
    import esmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic       direction,
    input  logic [4:0] channel,
    input  logic [4:0] chan_lo,
    input  logic [4:0] chan_hi,
    input  logic [3:0] event_kind,
    input  logic [7:0] subscriber_id,
    output logic       result_valid,
    output logic [1:0] result_kind,
    output logic [7:0] target_id,
    output logic       status,
    output logic [4:0] removed_count,
    output logic       last
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    esmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    esmt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .direction     (direction),
        .channel       (channel),
        .chan_lo       (chan_lo),
        .chan_hi       (chan_hi),
        .event_kind    (event_kind),
        .subscriber_id (subscriber_id),
        .result_valid  (result_valid),
        .result_kind   (result_kind),
        .target_id     (target_id),
        .status        (status),
        .removed_count (removed_count),
        .last          (last)
    );

endmodule

[rtl/esmt_datapath.sv]
// ----------------------------------------------------------------------------
// esmt_datapath: entry memory, counters, match logic and result registers
// Holds the ordered entry list in a single-port-read memory, scans it one
// entry per cycle for events and compacts it in place for deregistration.
// ----------------------------------------------------------------------------
module esmt_datapath
    import esmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output dp_status_t stat,
    input  logic       direction,
    input  logic [4:0] channel,
    input  logic [4:0] chan_lo,
    input  logic [4:0] chan_hi,
    input  logic [3:0] event_kind,
    input  logic [7:0] subscriber_id,
    output logic       result_valid,
    output logic [1:0] result_kind,
    output logic [7:0] target_id,
    output logic       status,
    output logic [4:0] removed_count,
    output logic       last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    entry_t mem [TABLE_DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] keep_reg, keep_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_id_reg, pend_id_next;
    entry_t           rd_data_reg;
    entry_t           req_entry_reg, req_entry_next;
    logic [4:0]       req_chan_reg, req_chan_next;

    logic             res_valid_reg, res_valid_next;
    logic [1:0]       res_kind_reg, res_kind_next;
    logic [7:0]       res_id_reg, res_id_next;
    logic             res_status_reg, res_status_next;
    logic [4:0]       res_removed_reg, res_removed_next;
    logic             res_last_reg, res_last_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           new_entry;
    logic             full;
    logic             match;
    logic [CNT_W-1:0] removed_diff;
    logic [CNT_W+4:0] removed_ext;

    assign new_entry = '{direction:   direction,
                         chan_lo:     chan_lo,
                         chan_hi:     chan_hi,
                         type_filter: event_kind,
                         subscriber:  subscriber_id};

    assign full         = count_reg >= CNT_W'(TABLE_DEPTH);
    assign removed_diff = count_reg - keep_reg;
    assign removed_ext  = {5'b0, removed_diff};

    assign match = (rd_data_reg.direction == req_entry_reg.direction)
                && ((rd_data_reg.chan_lo == 5'd0)
                    || ((req_chan_reg >= rd_data_reg.chan_lo)
                        && (req_chan_reg <= rd_data_reg.chan_hi)))
                && ((rd_data_reg.type_filter == 4'd0)
                    || (rd_data_reg.type_filter == req_entry_reg.type_filter));

    assign stat.all_issued = (rd_idx_reg == count_reg);
    assign stat.rd_valid   = rd_valid_reg;

    always_comb
    begin
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        keep_next        = keep_reg;
        rd_valid_next    = 1'b0;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        req_entry_next   = req_entry_reg;
        req_chan_next    = req_chan_reg;
        res_valid_next   = 1'b0;
        res_kind_next    = res_kind_reg;
        res_id_next      = res_id_reg;
        res_status_next  = STATUS_OK;
        res_removed_next = 5'd0;
        res_last_next    = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = count_reg[IDX_W-1:0];
        wr_data          = new_entry;

        if (cmd.load)
        begin
            req_entry_next = new_entry;
            req_chan_next  = channel;
        end

        if (cmd.do_register)
        begin
            res_valid_next = 1'b1;
            res_kind_next  = RES_REG_ACK;
            res_id_next    = subscriber_id;
            res_last_next  = 1'b1;
            if (full)
            begin
                res_status_next = STATUS_FULL;
            end
            else
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end

        if (cmd.start_scan)
        begin
            rd_idx_next     = '0;
            keep_next       = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.issue)
        begin
            rd_idx_next   = rd_idx_reg + 1'b1;
            rd_valid_next = 1'b1;
        end

        if (rd_valid_reg)
        begin
            if (cmd.dereg_mode)
            begin
                if (rd_data_reg.subscriber != req_entry_reg.subscriber)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = keep_reg[IDX_W-1:0];
                    wr_data   = rd_data_reg;
                    keep_next = keep_reg + 1'b1;
                end
            end
            else if (match)
            begin
                if (pend_valid_reg)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = RES_DELIVERY;
                    res_id_next    = pend_id_reg;
                end
                pend_valid_next = 1'b1;
                pend_id_next    = rd_data_reg.subscriber;
            end
        end

        if (cmd.ev_finish && pend_valid_reg)
        begin
            res_valid_next  = 1'b1;
            res_kind_next   = RES_DELIVERY;
            res_id_next     = pend_id_reg;
            res_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (cmd.dr_finish)
        begin
            count_next       = keep_reg;
            res_valid_next   = 1'b1;
            res_kind_next    = RES_DEREG_ACK;
            res_id_next      = req_entry_reg.subscriber;
            res_removed_next = removed_ext[4:0];
            res_last_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            keep_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            keep_reg       <= keep_next;
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg     <= pend_id_next;
        req_entry_reg   <= req_entry_next;
        req_chan_reg    <= req_chan_next;
        res_kind_reg    <= res_kind_next;
        res_id_reg      <= res_id_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        res_last_reg    <= res_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign result_valid  = res_valid_reg;
    assign result_kind   = res_kind_reg;
    assign target_id     = res_id_reg;
    assign status        = res_status_reg;
    assign removed_count = res_removed_reg;
    assign last          = res_last_reg;

endmodule

[rtl/esmt_ctrl.sv]
// ----------------------------------------------------------------------------
// esmt_ctrl: request sequencer of the event subscriber match table
// Decodes each accepted request and steps the datapath through the entry
// scan of an event or the compaction pass of a deregistration.
// ----------------------------------------------------------------------------
module esmt_ctrl
    import esmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] req_type,
    output logic       busy,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (req_type)
                        REQ_EVENT:
                        begin
                            cmd.start_scan = 1'b1;
                            state_next     = ST_EVENT;
                        end
                        REQ_REGISTER:
                        begin
                            cmd.do_register = 1'b1;
                        end
                        REQ_DEREGISTER:
                        begin
                            cmd.start_scan = 1'b1;
                            state_next     = ST_DEREG;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EVENT:
            begin
                cmd.issue = !stat.all_issued;
                if (stat.all_issued && !stat.rd_valid)
                begin
                    cmd.ev_finish = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DEREG:
            begin
                cmd.dereg_mode = 1'b1;
                cmd.issue      = !stat.all_issued;
                if (stat.all_issued && !stat.rd_valid)
                begin
                    cmd.dr_finish = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/esmt_checker.sv]
// ----------------------------------------------------------------------------
// esmt_checker: port-level checks of the event subscriber match table
// Watches the request and result ports and flags results that break the
// request sequencing of the table.
// ----------------------------------------------------------------------------
module esmt_checker
    import esmt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] req_type,
    input logic       result_valid,
    input logic [1:0] result_kind,
    input logic       status,
    input logic [4:0] removed_count,
    input logic       last
);

    a_reg_ack: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == REQ_REGISTER)
        |=> result_valid && (result_kind == RES_REG_ACK) && last)
        else $error("Register transaction without an acknowledge on the next cycle.");

    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((req_type == REQ_EVENT) || (req_type == REQ_DEREGISTER))
        |=> busy && !result_valid)
        else $error("Scan transaction did not hold the request port busy.");

    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind != RES_DELIVERY) |-> last)
        else $error("Acknowledge result not marked as last.");

    a_delivery_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == RES_DELIVERY)
        |-> (status == STATUS_OK) && (removed_count == 5'd0))
        else $error("Delivery result carries status or removed count.");

endmodule

bind event_subscriber_match_table_top esmt_checker u_esmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .result_valid  (result_valid),
    .result_kind   (result_kind),
    .status        (status),
    .removed_count (removed_count),
    .last          (last)
);
